>>> hdl/vna_pkg.sv
// vna_pkg: shared codes and widths for the vertex normal accumulator.
// No dependencies; imported by the top level and its checker.
`default_nettype none
package vna_pkg;
  localparam int IDX_W = 10;
  localparam int POS_W = 16;
  localparam int NRM_W = 16;
  localparam int SUM_W = 24;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 56;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_TRI  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_ZERO  = 2'd2;
  localparam logic [1:0] STAT_SAT   = 2'd3;
endpackage
`default_nettype wire

>>> hdl/vna_ram.sv
// vna_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hdl/vertex_normal_accumulator.sv
// vertex_normal_accumulator: per-vertex smoothed normals from triangle face normals.
// Depends on vna_pkg and vna_ram (position store and 3x24-bit sum store).
//
//  channel | ports            | word
//  input   | in_tvalid/tready | op, vertex_index, pos_x/y/z, corner_a/b/c
//  output  | out_tvalid/tready| normal_x/y/z, status
//
// A zero read sum or a degenerate triangle ends early with STAT_ZERO. Triangle and read
// time is set by the shared 21x21 multiplier, the bit-serial square root (21 steps),
// the one-bit-per-cycle normalizing shift (up to 19 steps) and three 15-step divisions.
// Out-of-range words skip the computation. After reset a clearing pass zeroes the sum
// store, with in_tready low. A finished word waits in the output register; a new word
// is taken while it waits, and the next result holds until that register frees.
`default_nettype none
module vertex_normal_accumulator #(
  parameter int VERTEX_COUNT = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // op[1:0], vertex_index[11:2], pos_x[27:12], pos_y[43:28], pos_z[59:44],
  // corner_a[69:60], corner_b[79:70], corner_c[89:80], zero fill
  input  wire logic [vna_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // normal_x[15:0], normal_y[31:16], normal_z[47:32], status[49:48], zero fill
  output logic      [vna_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import vna_pkg::*;

  localparam int AW = $clog2(VERTEX_COUNT);
  localparam logic [16:0] VC17 = 17'(VERTEX_COUNT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(VERTEX_COUNT - 1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_PRD  = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_SRD  = 4'd4;
  localparam logic [3:0] S_ZCHK = 4'd5;
  localparam logic [3:0] S_NORM = 4'd6;
  localparam logic [3:0] S_SQ   = 4'd7;
  localparam logic [3:0] S_SQRT = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_ACC  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  // input word fields
  logic [1:0]       in_op;
  logic [IDX_W-1:0] in_vi, in_ca, in_cb, in_cc;
  logic [3*POS_W-1:0] in_pos;
  assign in_op  = in_tdata[1:0];
  assign in_vi  = in_tdata[11:2];
  assign in_pos = in_tdata[59:12];
  assign in_ca  = in_tdata[69:60];
  assign in_cb  = in_tdata[79:70];
  assign in_cc  = in_tdata[89:80];

  logic vi_ok, tri_ok;
  assign vi_ok  = {7'b0, in_vi} < VC17;
  assign tri_ok = ({7'b0, in_ca} < VC17) && ({7'b0, in_cb} < VC17) &&
                  ({7'b0, in_cc} < VC17);

  // control and datapath registers
  logic [3:0]      st_r;
  logic [AW-1:0]   clr_r;
  logic [4:0]      step_r;
  logic [1:0]      comp_r;
  logic [1:0]      op_r;
  logic [1:0]      stat_r;
  logic            sat_r;
  logic [AW-1:0]   vidx_r;
  logic [AW-1:0]   cor_r [3];
  logic [3*POS_W-1:0] pp_r [3];
  logic signed [35:0] vec_r [3];
  logic            neg_r [3];
  logic [34:0]     mag_r [3];
  logic signed [41:0] prod_r;
  logic [41:0]     s_r, root_r, bit_r;
  logic [20:0]     len_r;
  logic [34:0]     rem_r;
  logic [14:0]     q_r;
  logic [NRM_W-1:0] n_r [3];
  logic            out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  // memories
  logic                  pos_we, sum_we;
  logic [AW-1:0]         pos_raddr, sum_raddr, sum_waddr;
  logic [3*POS_W-1:0]    pos_rdata;
  logic [3*SUM_W-1:0]    sum_rdata, sum_wdata;

  vna_ram #(.WIDTH(3*POS_W), .DEPTH(VERTEX_COUNT)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(AW'({6'b0, in_vi})), .wdata(in_pos),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );
  vna_ram #(.WIDTH(3*SUM_W), .DEPTH(VERTEX_COUNT)) u_sum_ram (
    .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
    .raddr(sum_raddr), .rdata(sum_rdata)
  );

  logic accept;
  assign in_tready = (st_r == S_IDLE);
  assign accept    = in_tready && in_tvalid;

  // result handed over when the output register is free or draining
  logic fin_go;
  assign fin_go = (st_r == S_FIN) && (!out_tvalid_r || out_tready);

  assign pos_we    = accept && (in_op == OP_LOAD) && vi_ok;
  assign pos_raddr = (step_r[1:0] == 2'd3) ? cor_r[2] : cor_r[step_r[1:0]];
  assign sum_raddr = (st_r == S_SRD) ? vidx_r : cor_r[comp_r];

  // saturating add of one face normal into one corner
  logic [SUM_W-1:0] sum_new [3];
  logic             sat_hit [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [SUM_W:0] t;
      t = $signed({sum_rdata[SUM_W*i+SUM_W-1], sum_rdata[SUM_W*i +: SUM_W]}) +
          $signed((SUM_W+1)'($signed(n_r[i])));
      sat_hit[i] = (t[SUM_W] != t[SUM_W-1]);
      if (!sat_hit[i]) begin
        sum_new[i] = t[SUM_W-1:0];
      end else if (t[SUM_W]) begin
        sum_new[i] = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
        sum_new[i] = {1'b0, {(SUM_W-1){1'b1}}};
      end
    end
  end

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = cor_r[comp_r];
    sum_wdata = '0;
    if (st_r == S_CLR) begin
      sum_we    = 1'b1;
      sum_waddr = clr_r;
    end else if (pos_we) begin
      sum_we    = 1'b1;
      sum_waddr = AW'({6'b0, in_vi});
    end else if (st_r == S_ACC && step_r[0]) begin
      sum_we    = 1'b1;
      sum_wdata = {sum_new[2], sum_new[1], sum_new[0]};
    end
  end

  // edges of the triangle, a is the shared corner
  logic signed [16:0] e1 [3], e2 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = 17'($signed(pp_r[1][POS_W*i +: POS_W])) -
              17'($signed(pp_r[0][POS_W*i +: POS_W]));
      e2[i] = 17'($signed(pp_r[2][POS_W*i +: POS_W])) -
              17'($signed(pp_r[0][POS_W*i +: POS_W]));
    end
  end

  // shared multiplier operand select
  logic signed [20:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (st_r == S_MUL) begin
      case (step_r[2:0])
        3'd0: begin mul_a = 21'(e1[1]); mul_b = 21'(e2[2]); end
        3'd1: begin mul_a = 21'(e1[2]); mul_b = 21'(e2[1]); end
        3'd2: begin mul_a = 21'(e1[2]); mul_b = 21'(e2[0]); end
        3'd3: begin mul_a = 21'(e1[0]); mul_b = 21'(e2[2]); end
        3'd4: begin mul_a = 21'(e1[0]); mul_b = 21'(e2[1]); end
        3'd5: begin mul_a = 21'(e1[1]); mul_b = 21'(e2[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (step_r[1:0] != 2'd3) begin
      mul_a = $signed({1'b0, mag_r[step_r[1:0]][19:0]});
      mul_b = mul_a;
    end
  end

  // largest magnitude for the normalizing shift
  logic [34:0] mag_max;
  always_comb begin
    mag_max = mag_r[0];
    if (mag_r[1] > mag_max) mag_max = mag_r[1];
    if (mag_r[2] > mag_max) mag_max = mag_r[2];
  end

  // square root step and division step
  logic [41:0] sq_cand;
  logic [35:0] div_trial;
  logic        div_ge;
  logic [14:0] q_fin;
  logic [1:0]  comp_nx;
  assign sq_cand   = root_r + bit_r;
  assign div_trial = {15'b0, len_r} << step_r[3:0];
  assign div_ge    = {1'b0, rem_r} >= div_trial;
  assign q_fin     = div_ge ? (q_r | (15'(1) << step_r[3:0])) : q_r;
  assign comp_nx   = (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;

  logic [20:0] root_fin;
  assign root_fin = (s_r >= sq_cand) ? 21'((root_r >> 1) + bit_r) : 21'(root_r >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_CLR;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      prod_r <= mul_a * mul_b;
      if (fin_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (st_r)
        // sweep the sum store to zero
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == LAST_ADDR) st_r <= S_IDLE;
        end
        S_IDLE: if (in_tvalid) begin
          op_r   <= in_op;
          sat_r  <= 1'b0;
          step_r <= '0;
          comp_r <= '0;
          vidx_r <= AW'({6'b0, in_vi});
          cor_r[0] <= AW'({6'b0, in_ca});
          cor_r[1] <= AW'({6'b0, in_cb});
          cor_r[2] <= AW'({6'b0, in_cc});
          case (in_op)
            OP_LOAD: begin
              stat_r <= vi_ok ? STAT_OK : STAT_RANGE;
              st_r   <= S_FIN;
            end
            OP_TRI: begin
              stat_r <= tri_ok ? STAT_OK : STAT_RANGE;
              st_r   <= tri_ok ? S_PRD : S_FIN;
            end
            OP_READ: begin
              stat_r <= vi_ok ? STAT_OK : STAT_RANGE;
              st_r   <= vi_ok ? S_SRD : S_FIN;
            end
            default: begin
              stat_r <= STAT_OK;
              st_r   <= S_FIN;
            end
          endcase
        end
        // fetch the three corner positions
        S_PRD: begin
          step_r <= (step_r == 5'd3) ? 5'd0 : step_r + 5'd1;
          if (step_r != 5'd0) pp_r[step_r[1:0] - 2'd1] <= pos_rdata;
          if (step_r == 5'd3) begin
            st_r   <= S_MUL;
            for (int i = 0; i < 3; i++) vec_r[i] <= '0;
          end
        end
        // cross product, one product per cycle, accumulated in the next cycle
        S_MUL: begin
          step_r <= step_r + 5'd1;
          if (step_r != 5'd0) begin
            if (step_r[0]) begin
              vec_r[2'((step_r - 5'd1) >> 1)] <= vec_r[2'((step_r - 5'd1) >> 1)]
                                                 + 36'(prod_r);
            end else begin
              vec_r[2'((step_r - 5'd1) >> 1)] <= vec_r[2'((step_r - 5'd1) >> 1)]
                                                 - 36'(prod_r);
            end
          end
          if (step_r == 5'd6) st_r <= S_ZCHK;
        end
        // fetch one vertex sum
        S_SRD: begin
          step_r <= step_r + 5'd1;
          if (step_r == 5'd1) begin
            for (int i = 0; i < 3; i++) begin
              vec_r[i] <= 36'($signed(sum_rdata[SUM_W*i +: SUM_W]));
            end
            st_r <= S_ZCHK;
          end
        end
        // split signs, reject the zero vector
        S_ZCHK: begin
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= vec_r[i][35];
            mag_r[i] <= vec_r[i][35] ? 35'(-vec_r[i]) : 35'(vec_r[i]);
          end
          if (vec_r[0] == '0 && vec_r[1] == '0 && vec_r[2] == '0) begin
            stat_r <= STAT_ZERO;
            st_r   <= S_FIN;
          end else begin
            st_r <= S_NORM;
          end
        end
        // one shift per cycle until the largest lies in [2^19, 2^20)
        S_NORM: begin
          if (mag_max >= 35'(1 << 20)) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
          end else if (mag_max < 35'(1 << 19)) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
          end else begin
            s_r    <= '0;
            step_r <= '0;
            st_r   <= S_SQ;
          end
        end
        // sum of squares
        S_SQ: begin
          step_r <= step_r + 5'd1;
          if (step_r != 5'd0) s_r <= s_r + 42'(prod_r);
          if (step_r == 5'd3) begin
            root_r <= '0;
            bit_r  <= 42'(1) << 40;
            st_r   <= S_SQRT;
          end
        end
        // bit-serial integer square root
        S_SQRT: begin
          if (s_r >= sq_cand) begin
            s_r    <= s_r - sq_cand;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            len_r  <= root_fin;
            rem_r  <= 35'({mag_r[0][19:0], 14'b0}) + 35'(root_fin[20:1]);
            q_r    <= '0;
            comp_r <= '0;
            step_r <= 5'd14;
            st_r   <= S_DIV;
          end
        end
        // rounded quotient, one bit per cycle, three components in turn
        S_DIV: begin
          if (step_r != 5'd0) begin
            if (div_ge) rem_r <= 35'({1'b0, rem_r} - div_trial);
            q_r    <= q_fin;
            step_r <= step_r - 5'd1;
          end else begin
            n_r[comp_r] <= neg_r[comp_r] ? NRM_W'(-{1'b0, q_fin}) : NRM_W'({1'b0, q_fin});
            q_r    <= '0;
            rem_r  <= 35'({mag_r[comp_nx][19:0], 14'b0}) + 35'(len_r[20:1]);
            if (comp_r == 2'd2) begin
              comp_r <= '0;
              step_r <= '0;
              st_r   <= (op_r == OP_TRI) ? S_ACC : S_FIN;
            end else begin
              comp_r <= comp_nx;
              step_r <= 5'd14;
            end
          end
        end
        // read-modify-write of the corner sums, a then b then c
        S_ACC: begin
          step_r <= step_r + 5'd1;
          if (step_r[0]) begin
            if (sat_hit[0] || sat_hit[1] || sat_hit[2]) sat_r <= 1'b1;
            comp_r <= comp_nx;
            if (comp_r == 2'd2) begin
              st_r <= S_FIN;
              if (sat_r || sat_hit[0] || sat_hit[1] || sat_hit[2]) stat_r <= STAT_SAT;
            end
          end
        end
        // hand the word to the output register
        S_FIN: begin
          if (fin_go) begin
            if (op_r == OP_READ && stat_r == STAT_OK) begin
              out_tdata_r <= {6'b0, stat_r, n_r[2], n_r[1], n_r[0]};
            end else begin
              out_tdata_r <= {6'b0, stat_r, {(3*NRM_W){1'b0}}};
            end
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
endmodule
`default_nettype wire

>>> hdl/vna_checker.sv
// vna_checker: port-level assertions for vertex_normal_accumulator, with bind.
// Depends on vna_pkg.
`default_nettype none
module vna_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [vna_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import vna_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed under stall");

  // one word at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // words with a status other than OK carry zero normals
  a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[49:48] != STAT_OK |-> out_tdata[47:0] == '0)
    else $error("nonzero normal with error status");

  // reset empties the output register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire
